// ----- rtl/qftv_pkg.sv -----
// package for the two-vector rotation quaternion pipeline
// holds widths, stage counts and the square root and divide step functions
`default_nettype none

package qftv_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;
  localparam int QFRAC      = 14;
  localparam int MAG_BITS   = 30;
  localparam int OPP_SHIFT  = 20;
  localparam int PIPE_DEPTH = 2 * (SQRT_STEPS + 1) + DIV_STEPS + 8;

  typedef struct packed {
    logic signed [32:0] dot;
    logic signed [32:0] cx;
    logic signed [32:0] cy;
    logic signed [32:0] cz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } vec_t;

  typedef struct packed {
    logic [63:0] x;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [14:0] low;
    logic [14:0] q;
  } divl_t;

  // one radix-4 digit of the integer square root
  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [35:0] remc;
    logic [35:0] trial;
    sqrt_t r;
    remc  = {s.rem, s.x[63:62]};
    trial = {2'b00, s.root, 2'b01};
    r.x   = {s.x[61:0], 2'b00};
    if (remc >= trial) begin
      r.rem  = 34'(remc - trial);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = remc[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // one restoring divide step
  function automatic divl_t div_step(divl_t d, logic [30:0] den);
    logic [31:0] remc;
    divl_t r;
    remc  = {d.rem, d.low[14]};
    r.low = {d.low[13:0], 1'b0};
    if (remc >= {1'b0, den}) begin
      r.rem = 31'(remc - {1'b0, den});
      r.q   = {d.q[13:0], 1'b1};
    end else begin
      r.rem = remc[30:0];
      r.q   = {d.q[13:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/quaternion_from_two_vectors_top.sv -----
// shortest-arc rotation quaternion between two integer 3-vectors, Q1.14 out
// depends on qftv_pkg
// accepts one request per cycle; the whole pipeline holds while the result waits
// the two 32-step square roots and the 15-step divide set the depth
// reset clears only the stage valid bits; payload registers are not reset
`default_nettype none

module quaternion_from_two_vectors_top import qftv_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire signed [15:0]  from_x,
  input  wire signed [15:0]  from_y,
  input  wire signed [15:0]  from_z,
  input  wire signed [15:0]  to_x,
  input  wire signed [15:0]  to_y,
  input  wire signed [15:0]  to_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [15:0] q_real,
  output logic signed [15:0] q_x,
  output logic signed [15:0] q_y,
  output logic signed [15:0] q_z,
  output logic               degenerate
);

  logic en;
  logic [PIPE_DEPTH-1:0] vld;

  assign en        = !vld[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // products
  logic signed [31:0] pxx, pyy, pzz, qxx, qyy, qzz;
  logic signed [31:0] dxx, dyy, dzz;
  logic signed [31:0] ayz, azy, azx, axz, axy, ayx;

  always_comb begin
    pxx = from_x * from_x;
    pyy = from_y * from_y;
    pzz = from_z * from_z;
    qxx = to_x * to_x;
    qyy = to_y * to_y;
    qzz = to_z * to_z;
    dxx = from_x * to_x;
    dyy = from_y * to_y;
    dzz = from_z * to_z;
    ayz = from_y * to_z;
    azy = from_z * to_y;
    azx = from_z * to_x;
    axz = from_x * to_z;
    axy = from_x * to_y;
    ayx = from_y * to_x;
  end

  logic [31:0] la, lb;
  vec_t        f1;

  always_ff @(posedge clk) begin
    if (en) begin
      la     <= 32'(pxx) + 32'(pyy) + 32'(pzz);
      lb     <= 32'(qxx) + 32'(qyy) + 32'(qzz);
      f1.dot <= 33'(dxx) + 33'(dyy) + 33'(dzz);
      f1.cx  <= 33'(ayz) - 33'(azy);
      f1.cy  <= 33'(azx) - 33'(axz);
      f1.cz  <= 33'(axy) - 33'(ayx);
      f1.ax  <= from_x;
      f1.ay  <= from_y;
      f1.az  <= from_z;
    end
  end

  // sqrt of |a|^2 |b|^2
  sqrt_t sa   [SQRT_STEPS+1];
  vec_t  sa_f [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sa[0].x    <= la * lb;
      sa[0].rem  <= '0;
      sa[0].root <= '0;
      sa_f[0]    <= f1;
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqa
    always_ff @(posedge clk) begin
      if (en) begin
        sa[k]   <= sqrt_step(sa[k-1]);
        sa_f[k] <= sa_f[k-1];
      end
    end
  end

  // real part
  logic signed [34:0] w;
  logic [31:0]        wn;
  vec_t               wf;

  always_ff @(posedge clk) begin
    if (en) begin
      w  <= $signed({3'b000, sa[SQRT_STEPS].root}) + 35'(sa_f[SQRT_STEPS].dot);
      wn <= sa[SQRT_STEPS].root;
      wf <= sa_f[SQRT_STEPS];
    end
  end

  // opposite vectors check and component select
  logic signed [34:0] comp_next [4];
  logic signed [34:0] comp [4];
  logic               opp;
  logic signed [16:0] ex, ez;
  logic [16:0]        mx, mz;

  always_comb begin
    ex  = 17'(wf.ax);
    ez  = 17'(wf.az);
    mx  = ex[16] ? 17'(-ex) : 17'(ex);
    mz  = ez[16] ? 17'(-ez) : 17'(ez);
    opp = w[34] || ({w, {OPP_SHIFT{1'b0}}} < {{(OPP_SHIFT + 3){1'b0}}, wn});
    if (opp) begin
      comp_next[0] = '0;
      if (mx > mz) begin
        comp_next[1] = -35'(wf.ay);
        comp_next[2] = 35'(wf.ax);
        comp_next[3] = '0;
      end else begin
        comp_next[1] = '0;
        comp_next[2] = -35'(wf.az);
        comp_next[3] = 35'(wf.ay);
      end
    end else begin
      comp_next[0] = w;
      comp_next[1] = 35'(wf.cx);
      comp_next[2] = 35'(wf.cy);
      comp_next[3] = 35'(wf.cz);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp <= comp_next;
    end
  end

  // magnitudes and signs
  logic [3:0][34:0] mag;
  logic [3:0]       mneg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mneg[i] <= comp[i][34];
        mag[i]  <= comp[i][34] ? 35'(-comp[i]) : 35'(comp[i]);
      end
    end
  end

  // common shift below 2^30
  logic [34:0]               or_all;
  logic [2:0]                shamt;
  logic [3:0][MAG_BITS-1:0]  sm;
  logic [3:0]                sneg;

  always_comb begin
    or_all = mag[0] | mag[1] | mag[2] | mag[3];
    shamt  = '0;
    for (int i = 0; i < 5; i++) begin
      if (or_all[MAG_BITS+i]) begin
        shamt = 3'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sm[i] <= MAG_BITS'(mag[i] >> shamt);
      end
      sneg <= mneg;
    end
  end

  // squares
  logic [3:0][2*MAG_BITS-1:0] sq;
  logic [3:0][MAG_BITS-1:0]   qm;
  logic [3:0]                 qneg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq[i] <= sm[i] * sm[i];
      end
      qm   <= sm;
      qneg <= sneg;
    end
  end

  // sqrt of the sum of squares
  sqrt_t                    sb     [SQRT_STEPS+1];
  logic [3:0][MAG_BITS-1:0] sb_m   [SQRT_STEPS+1];
  logic [3:0]               sb_neg [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0].x    <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]) + 64'(sq[3]);
      sb[0].rem  <= '0;
      sb[0].root <= '0;
      sb_m[0]    <= qm;
      sb_neg[0]  <= qneg;
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqb
    always_ff @(posedge clk) begin
      if (en) begin
        sb[k]     <= sqrt_step(sb[k-1]);
        sb_m[k]   <= sb_m[k-1];
        sb_neg[k] <= sb_neg[k-1];
      end
    end
  end

  // divide setup: (mag * 2^14 + N/2) / N
  divl_t [3:0] dv   [DIV_STEPS+1];
  logic [30:0] dn   [DIV_STEPS+1];
  logic [3:0]  dneg [DIV_STEPS+1];
  logic [30:0] nrm;
  logic [44:0] num [4];

  always_comb begin
    nrm = sb[SQRT_STEPS].root[30:0];
    for (int i = 0; i < 4; i++) begin
      num[i] = {1'b0, sb_m[SQRT_STEPS][i], {QFRAC{1'b0}}} + 45'(nrm >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dv[0][i].rem <= {1'b0, num[i][44:15]};
        dv[0][i].low <= num[i][14:0];
        dv[0][i].q   <= '0;
      end
      dn[0]   <= nrm;
      dneg[0] <= sb_neg[SQRT_STEPS];
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          dv[k][i] <= div_step(dv[k-1][i], dn[k-1]);
        end
        dn[k]   <= dn[k-1];
        dneg[k] <= dneg[k-1];
      end
    end
  end

  // output register
  logic signed [15:0] res [4];
  logic               zero_norm;

  always_comb begin
    zero_norm = (dn[DIV_STEPS] == '0);
    for (int i = 0; i < 4; i++) begin
      if (zero_norm) begin
        res[i] = '0;
      end else if (dneg[DIV_STEPS][i]) begin
        res[i] = -$signed({1'b0, dv[DIV_STEPS][i].q});
      end else begin
        res[i] = $signed({1'b0, dv[DIV_STEPS][i].q});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_real     <= res[0];
      q_x        <= res[1];
      q_y        <= res[2];
      q_z        <= res[3];
      degenerate <= zero_norm;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for quaternion_from_two_vectors_top
// predicts each shortest-arc quaternion in integer math and checks results in order
// depends on rtl/qftv_pkg.sv and rtl/quaternion_from_two_vectors_top.sv
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY   = 89;
  localparam int WDOG_MAX  = 20000;
  localparam int QONE      = 16384;
  localparam int MAG_LIMIT_BITS = 30;
  localparam int OPP_SHIFT = 20;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               degen;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] from_x = '0, from_y = '0, from_z = '0;
  logic signed [15:0] to_x = '0, to_y = '0, to_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] q_real, q_x, q_y, q_z;
  logic degenerate;

  quaternion_from_two_vectors_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .from_x(from_x), .from_y(from_y), .from_z(from_z),
    .to_x(to_x), .to_y(to_y), .to_z(to_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .q_real(q_real), .q_x(q_x), .q_y(q_y), .q_z(q_z), .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  quat_t expected_quats[$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_opposite = 0;
  int n_degen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int wdog = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(64'd0) - v : v;
  endfunction

  function automatic quat_t shortest_arc(logic signed [15:0] a[3], logic signed [15:0] b[3]);
    longint ax, ay, az, bx, by, bz, nrm;
    longint comp[4];
    longint unsigned la, lb, mag[4], maxm, sum, norm, q;
    int s;
    quat_t r;
    ax = a[0]; ay = a[1]; az = a[2];
    bx = b[0]; by = b[1]; bz = b[2];
    la = ax * ax + ay * ay + az * az;
    lb = bx * bx + by * by + bz * bz;
    nrm = int_sqrt(la * lb);
    comp[0] = nrm + ax * bx + ay * by + az * bz;
    if (comp[0] < 0 || comp[0] * (64'sd1 <<< OPP_SHIFT) < nrm) begin
      comp[0] = 0;
      if (abs64(ax) > abs64(az)) begin
        comp[1] = -ay; comp[2] = ax; comp[3] = 0;
      end else begin
        comp[1] = 0; comp[2] = -az; comp[3] = ay;
      end
    end else begin
      comp[1] = ay * bz - az * by;
      comp[2] = az * bx - ax * bz;
      comp[3] = ax * by - ay * bx;
    end
    maxm = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = abs64(comp[i]);
      if (mag[i] > maxm) maxm = mag[i];
    end
    s = 0;
    while ((maxm >> s) >= (64'd1 << MAG_LIMIT_BITS)) s++;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] >>= s;
      sum += mag[i] * mag[i];
    end
    norm = int_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      q = 0;
      if (norm != 0) q = (mag[i] * QONE + norm / 2) / norm;
      if (comp[i] < 0) q = 64'd0 - q;
      case (i)
        0: r.w = q[15:0];
        1: r.x = q[15:0];
        2: r.y = q[15:0];
        default: r.z = q[15:0];
      endcase
    end
    r.degen = (norm == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d", n_results, what, got, want);
  endtask

  task automatic send_request(logic signed [15:0] a[3], logic signed [15:0] b[3]);
    quat_t e;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    from_x <= a[0]; from_y <= a[1]; from_z <= a[2];
    to_x <= b[0]; to_y <= b[1]; to_z <= b[2];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = shortest_arc(a, b);
    expected_quats.push_back(e);
    n_requests++;
    if (e.degen) n_degen++;
    else if (e.w == 0) n_opposite++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        quat_t e;
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = expected_quats.pop_front();
          if (q_real !== e.w) report_mismatch("q_real", q_real, e.w);
          if (q_x !== e.x) report_mismatch("q_x", q_x, e.x);
          if (q_y !== e.y) report_mismatch("q_y", q_y, e.y);
          if (q_z !== e.z) report_mismatch("q_z", q_z, e.z);
          if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
        end
        n_results++;
      end
      out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired with %0d results outstanding", expected_quats.size());
      $display("** quaternion_from_two_vectors_top: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'(int'($urandom_range(16)) - 8);
      1: return $urandom_range(1) ? 16'sd32767 : -16'sd32767;
      2: return -16'sd32768;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pair(int a0, int a1, int a2, int b0, int b1, int b2);
    logic signed [15:0] a[3], b[3];
    a = '{16'(a0), 16'(a1), 16'(a2)};
    b = '{16'(b0), 16'(b1), 16'(b2)};
    send_request(a, b);
  endtask

  task automatic test_directed();
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(1, 2, 3, 2, 4, 6);
    send_pair(32767, 32767, 32767, -32767, -32767, -32767);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(-32768, 0, 0, 32767, 0, 0);
    send_pair(0, 5, 1, 0, -5, -1);
    send_pair(3, 1, 7, -3, -1, -7);
    send_pair(0, 0, 0, 1, 2, 3);
    send_pair(4, 5, 6, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(32767, 1, 0, 32767, 0, 0);
    send_pair(0, 0, -32768, 32767, 32767, -32768);
    send_pair(-1, -1, -1, 1, 1, 1);
    send_pair(12345, -23456, 31000, -32768, 777, 5);
  endtask

  task automatic test_random(int count);
    logic signed [15:0] a[3], b[3];
    int k;
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 3; j++) a[j] = rand_comp();
      k = $urandom_range(9);
      for (int j = 0; j < 3; j++) begin
        if (k == 0) b[j] = -a[j];
        else if (k == 1) b[j] = a[j];
        else if (k == 2) b[j] = 16'(-int'(a[j]) + int'($urandom_range(2)) - 1);
        else b[j] = rand_comp();
      end
      send_request(a, b);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 37; recv_idle_pct = 58;
    test_directed();
    test_random(300);
    drain();
    send_idle_pct = 58; recv_idle_pct = 37;
    test_random(300);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(300);
    drain();
    $display("sent %0d vector pairs, %0d results checked", n_requests, n_results);
    $display("%0d opposite-vector and %0d zero-length cases seen", n_opposite, n_degen);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("** quaternion_from_two_vectors_top: PASSED **");
    end else begin
      $display("** quaternion_from_two_vectors_top: FAILED **");
    end
    $finish;
  end

endmodule
